FILE: src/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg - shared types and constants for the scrollback text window
// Operation codes, controller states and the command/status structs between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int LINES_DEF   = 4;
  localparam int COLUMNS_DEF = 16;

  localparam logic [7:0] CR_CODE    = 8'd13;
  localparam logic [7:0] SPACE_CODE = 8'd32;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_SCROLL = 2'd2,
    FUNC_UPDATE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL_ALL,
    ST_FILL_LINE,
    ST_SCAN,
    ST_TAIL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic accept;    // item taken this cycle
    logic fill_all;  // sweep whole store and shadow
    logic fill_line; // sweep bottom line
    logic zero_val;  // sweep writes zero rather than space
    logic scan;      // issue one compare read
    logic flush;     // release held result as last
  } cmd_t;

  typedef struct packed {
    logic full_last;
    logic line_last;
    logic scan_last;
    logic need_shift;
  } status_t;

endpackage

FILE: src/stw_ctrl.sv
// ----------------------------------------------------------------------------
// stw_ctrl - sequencer for the scrollback text window
// Decodes accepted items and steps the datapath through sweeps and scans.
// ----------------------------------------------------------------------------
module stw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       func_i,
  input  stw_pkg::status_t status_i,
  output stw_pkg::cmd_t    cmd_o,
  output logic             busy
);
  import stw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill_all = 1'b1;
        cmd_o.zero_val = 1'b1;
        if (status_i.full_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          case (func_i)
            FUNC_ADD:    if (status_i.need_shift) state_d = ST_FILL_LINE;
            FUNC_CLEAR:  state_d = ST_FILL_ALL;
            FUNC_SCROLL: state_d = ST_IDLE;
            default:     state_d = ST_SCAN;
          endcase
        end
      end
      ST_FILL_ALL: begin
        cmd_o.fill_all = 1'b1;
        if (status_i.full_last) state_d = ST_IDLE;
      end
      ST_FILL_LINE: begin
        cmd_o.fill_line = 1'b1;
        if (status_i.line_last) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/stw_datapath.sv
// ----------------------------------------------------------------------------
// stw_datapath - line store, panel shadow, cursor and compare pipeline
// Line store is a ring of lines addressed {physical line, column}; a shift
// moves the head pointer and the new bottom line is swept with spaces.
// ----------------------------------------------------------------------------
module stw_datapath #(
  parameter int LINES   = stw_pkg::LINES_DEF,
  parameter int COLUMNS = stw_pkg::COLUMNS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stw_pkg::cmd_t     cmd_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        char_code_i,
  input  logic signed [7:0] scroll_amount_i,
  output stw_pkg::status_t  status_o,
  output logic              result_valid_o,
  output logic              panel_row_o,
  output logic [3:0]        panel_column_o,
  output logic [7:0]        out_char_o,
  output logic              last_o
);
  import stw_pkg::*;

  localparam int LW       = $clog2(LINES);
  localparam int CW       = $clog2(COLUMNS);
  localparam int AW       = LW + CW;
  localparam int DEPTH    = LINES * (2 ** CW);
  localparam int SH_AW    = CW + 1;
  localparam int SH_DEPTH = 2 ** SH_AW;
  localparam int SW       = ((LW > 8) ? LW : 8) + 2;

  localparam logic [LW:0]          LINES_W    = (LW + 1)'(LINES);
  localparam logic [LW-1:0]        LAST_LINE  = LW'(LINES - 1);
  localparam logic [LW-1:0]        BOT2       = LW'(LINES - 2);
  localparam logic [CW-1:0]        LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [AW-1:0]        FULL_LAST  = AW'(DEPTH - 1);
  localparam logic [AW-1:0]        LINE_LAST  = AW'(COLUMNS - 1);
  localparam logic [AW-1:0]        SCAN_LAST  = AW'(SH_DEPTH - 1);
  localparam logic [CW:0]          COLUMNS_W  = (CW + 1)'(COLUMNS);
  localparam logic signed [SW-1:0] BACK_MAX_S = SW'(LINES - 2);

  function automatic logic [LW-1:0] line_phys(input logic [LW-1:0] head,
                                              input logic [LW-1:0] lline);
    logic [LW:0] s;
    s = {1'b0, head} + {1'b0, lline};
    if (s >= LINES_W) s = s - LINES_W;
    return s[LW-1:0];
  endfunction

  logic [7:0] store_mem [DEPTH];
  logic [7:0] shad_mem  [SH_DEPTH];

  logic [AW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] cur_line_q, cur_line_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [LW-1:0] back_q, back_d;

  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata, st_rd_q;
  logic             sh_we;
  logic [SH_AW-1:0] sh_waddr;
  logic [7:0]       sh_wdata, sh_rd_q;

  logic          s1_valid_q, s1_valid_d;
  logic          s1_row_q;
  logic [CW-1:0] s1_col_q;
  logic          hit;

  logic          pend_valid_q, pend_valid_d;
  logic          pend_row_q;
  logic [CW-1:0] pend_col_q;
  logic [7:0]    pend_char_q;

  logic          emit, emit_last;
  logic          out_valid_q;
  logic          out_row_q, out_last_q;
  logic [CW-1:0] out_col_q;
  logic [7:0]    out_char_q;

  logic          line_inc;
  logic [LW:0]   line_next;
  logic [LW-1:0] base_line;
  logic [CW:0]   col_ext;
  logic signed [SW-1:0] sc_next;
  logic [7:0]    fill_val;

  // ---- cursor, scroll and head ----
  assign line_inc  = (char_code_i == CR_CODE) || (cur_col_q == LAST_COL);
  assign line_next = {1'b0, cur_line_q} + (LW + 1)'(1);
  assign base_line = BOT2 - back_q;
  assign col_ext   = {1'b0, cnt_q[CW-1:0]};
  assign sc_next   = $signed({{(SW - LW){1'b0}}, back_q}) - SW'(scroll_amount_i);
  assign fill_val  = cmd_i.zero_val ? 8'd0 : SPACE_CODE;

  assign status_o.full_last  = (cnt_q == FULL_LAST);
  assign status_o.line_last  = (cnt_q == LINE_LAST);
  assign status_o.scan_last  = (cnt_q == SCAN_LAST);
  assign status_o.need_shift = (func_i == FUNC_ADD) && line_inc && (line_next >= LINES_W);

  always_comb begin
    head_d     = head_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    back_d     = back_q;
    cnt_d      = (cmd_i.fill_all || cmd_i.fill_line || cmd_i.scan) ?
                 cnt_q + AW'(1) : '0;
    if (cmd_i.accept) begin
      case (func_i)
        FUNC_ADD: begin
          back_d = '0;
          if (line_inc) begin
            cur_col_d = '0;
            if (line_next >= LINES_W) begin
              cur_line_d = LAST_LINE;
              head_d     = line_phys(head_q, LW'(1));
            end else begin
              cur_line_d = line_next[LW-1:0];
            end
          end else begin
            cur_col_d = cur_col_q + CW'(1);
          end
        end
        FUNC_CLEAR: begin
          cur_col_d  = '0;
          cur_line_d = BOT2;
          back_d     = '0;
          head_d     = '0;
        end
        FUNC_SCROLL: begin
          if (sc_next < 0) back_d = '0;
          else if (sc_next > BACK_MAX_S) back_d = BOT2;
          else back_d = sc_next[LW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      head_q     <= '0;
      cur_line_q <= BOT2;
      cur_col_q  <= '0;
      back_q     <= '0;
    end else begin
      cnt_q      <= cnt_d;
      head_q     <= head_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      back_q     <= back_d;
    end
  end

  // ---- line store ----
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cnt_q;
    st_wdata = fill_val;
    if (cmd_i.fill_all) begin
      st_we = 1'b1;
    end else if (cmd_i.fill_line) begin
      st_we    = 1'b1;
      st_waddr = {line_phys(head_q, LAST_LINE), cnt_q[CW-1:0]};
    end else if (cmd_i.accept && (func_i == FUNC_ADD) && (char_code_i != CR_CODE)) begin
      st_we    = 1'b1;
      st_waddr = {line_phys(head_q, cur_line_q), cur_col_q};
      st_wdata = char_code_i;
    end
  end

  assign st_raddr = {line_phys(head_q, base_line + LW'(cnt_q[CW])), cnt_q[CW-1:0]};

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rd_q <= store_mem[st_raddr];
  end

  // ---- panel shadow and compare stage ----
  assign hit = s1_valid_q && (st_rd_q != sh_rd_q);

  always_comb begin
    sh_we    = 1'b0;
    sh_waddr = cnt_q[SH_AW-1:0];
    sh_wdata = fill_val;
    if (cmd_i.fill_all) begin
      sh_we = (cnt_q[AW-1:SH_AW] == '0);
    end else if (hit) begin
      sh_we    = 1'b1;
      sh_waddr = {s1_row_q, s1_col_q};
      sh_wdata = st_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sh_we) shad_mem[sh_waddr] <= sh_wdata;
    sh_rd_q <= shad_mem[cnt_q[SH_AW-1:0]];
  end

  // cells past the last column exist only when COLUMNS is not a power of two
  assign s1_valid_d = cmd_i.scan && (col_ext < COLUMNS_W);

  // one changed cell is held back so that the final one can carry last
  always_comb begin
    emit         = 1'b0;
    emit_last    = 1'b0;
    pend_valid_d = pend_valid_q;
    if (hit) begin
      emit         = pend_valid_q;
      pend_valid_d = 1'b1;
    end else if (cmd_i.flush) begin
      emit         = pend_valid_q;
      emit_last    = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= cnt_q[CW];
    s1_col_q <= cnt_q[CW-1:0];
    if (hit) begin
      pend_row_q  <= s1_row_q;
      pend_col_q  <= s1_col_q;
      pend_char_q <= st_rd_q;
    end
    if (emit) begin
      out_row_q  <= pend_row_q;
      out_col_q  <= pend_col_q;
      out_char_q <= pend_char_q;
      out_last_q <= emit_last;
    end
  end

  assign result_valid_o = out_valid_q;
  assign panel_row_o    = out_row_q;
  assign panel_column_o = 4'(out_col_q);
  assign out_char_o     = out_char_q;
  assign last_o         = out_last_q;

endmodule

FILE: src/scrollback_text_window.sv
// ----------------------------------------------------------------------------
// scrollback_text_window - scrollback line store for a two-row text panel
// Holds LINES lines of text, a shadow of the panel and emits changed cells.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low. func_i
// selects add char, clear, scroll or update. Only update produces results:
// one per panel cell that differs from the shadow, each shown for a single
// cycle with result_valid_o high and last_o set on the final one. The
// receiver cannot stall; there is no back-pressure on the results.
// Work per item (busy from accept to ready again):
//   add char: none, or a bottom line sweep when the store shifts
//   scroll: none
//   clear: sweeps store and shadow with spaces (one store write per cycle)
//   update: scans the shadow, one shadow cell compared per cycle;
//   results trail the compare by one changed cell.
// Shift is a head pointer move, so its cost is the line sweep alone.
// After reset the block is busy while it sweeps zeros through store and
// shadow, before the first item is taken.
// ----------------------------------------------------------------------------
module scrollback_text_window #(
  parameter int LINES   = stw_pkg::LINES_DEF,
  parameter int COLUMNS = stw_pkg::COLUMNS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        func_i,
  input  logic [7:0]        char_code_i,
  input  logic signed [7:0] scroll_amount_i,
  output logic              result_valid_o,
  output logic              panel_row_o,
  output logic [3:0]        panel_column_o,
  output logic [7:0]        out_char_o,
  output logic              last_o
);
  import stw_pkg::*;

  cmd_t    cmd;
  status_t status;

  stw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  stw_datapath #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .char_code_i     (char_code_i),
    .scroll_amount_i (scroll_amount_i),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .panel_row_o     (panel_row_o),
    .panel_column_o  (panel_column_o),
    .out_char_o      (out_char_o),
    .last_o          (last_o)
  );

endmodule

FILE: src/stw_checker.sv
// ----------------------------------------------------------------------------
// stw_checker - port level checks for the scrollback text window
// Result timing against busy and the item handshake.
// ----------------------------------------------------------------------------
module stw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [1:0]        func_i,
  input logic              result_valid_o,
  input logic              last_o
);
  import stw_pkg::*;

  // results only come out of an update in progress
  a_result_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result outside an update");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("result after last");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result right after an accepted item");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == FUNC_CLEAR)) |=> busy)
    else $error("clear did not sweep");

  a_scroll_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == FUNC_SCROLL)) |=> !busy)
    else $error("scroll held the block");

endmodule

bind scrollback_text_window stw_checker u_stw_checker (.*);

FILE: verif/tb_scrollback_text_window.sv
// ----------------------------------------------------------------------------
// tb_scrollback_text_window - self-checking bench for the scrollback window
// Drives add char, clear, scroll and update commands in random bursts. A
// behavioural copy of the line store and panel shadow predicts every changed
// cell, and each one the block emits is checked field by field.
// ----------------------------------------------------------------------------
module tb_scrollback_text_window;
  import stw_pkg::*;

  localparam int LINES      = LINES_DEF;
  localparam int COLUMNS    = COLUMNS_DEF;
  localparam int RAND_ITEMS = 500;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 80;

  typedef struct {
    func_e             op;
    logic [7:0]        code;
    logic signed [7:0] amount;
  } panel_cmd_t;

  typedef struct {
    logic       row;
    logic [3:0] col;
    logic [7:0] ch;
    logic       last;
  } cell_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  func_e             func = FUNC_ADD;
  logic [7:0]        char_code = 8'd0;
  logic signed [7:0] scroll_amount = 8'sd0;
  logic              result_valid;
  logic              panel_row;
  logic [3:0]        panel_column;
  logic [7:0]        out_char;
  logic              last;

  scrollback_text_window dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func),
    .char_code_i     (char_code),
    .scroll_amount_i (scroll_amount),
    .result_valid_o  (result_valid),
    .panel_row_o     (panel_row),
    .panel_column_o  (panel_column),
    .out_char_o      (out_char),
    .last_o          (last)
  );

  // window model
  logic [7:0] line_buf   [LINES][COLUMNS];
  logic [7:0] shadow_buf [2][COLUMNS];
  int         wr_col;
  int         wr_line;
  int         view_back;

  panel_cmd_t cmd_backlog[$];
  cell_t      cells_due[$];

  bit showing;
  bit taken;
  int burst_left;
  int gap_left;
  int quiet_cycles;
  int errors;
  int n_items, n_updates, n_shifts, n_clears, n_cells;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic queue_cmd(input func_e op, input logic [7:0] code,
                           input logic signed [7:0] amount);
    panel_cmd_t c;
    c.op = op;
    c.code = code;
    c.amount = amount;
    cmd_backlog.push_back(c);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic advance_window(input panel_cmd_t c);
    int    nxt;
    int    base;
    cell_t prev;
    bit    have_prev;
    have_prev = 0;
    case (c.op)
      FUNC_ADD: begin
        view_back = 0;
        if (c.code == CR_CODE) begin
          wr_col = 0;
          wr_line++;
        end else begin
          line_buf[wr_line][wr_col] = c.code;
          wr_col++;
          if (wr_col >= COLUMNS) begin
            wr_col = 0;
            wr_line++;
          end
        end
        if (wr_line >= LINES) begin
          wr_line = LINES - 1;
          for (int l = 0; l < LINES - 1; l++)
            for (int k = 0; k < COLUMNS; k++) line_buf[l][k] = line_buf[l+1][k];
          for (int k = 0; k < COLUMNS; k++) line_buf[LINES-1][k] = SPACE_CODE;
          n_shifts++;
        end
      end
      FUNC_CLEAR: begin
        for (int l = 0; l < LINES; l++)
          for (int k = 0; k < COLUMNS; k++) line_buf[l][k] = SPACE_CODE;
        for (int r = 0; r < 2; r++)
          for (int k = 0; k < COLUMNS; k++) shadow_buf[r][k] = SPACE_CODE;
        wr_col = 0;
        wr_line = LINES - 2;
        view_back = 0;
        n_clears++;
      end
      FUNC_SCROLL: begin
        nxt = view_back - int'(c.amount);
        if (nxt < 0) nxt = 0;
        else if (nxt > LINES - 2) nxt = LINES - 2;
        view_back = nxt;
      end
      default: begin
        base = LINES - 2 - view_back;
        for (int r = 0; r < 2; r++) begin
          for (int k = 0; k < COLUMNS; k++) begin
            if (shadow_buf[r][k] != line_buf[base+r][k]) begin
              shadow_buf[r][k] = line_buf[base+r][k];
              // hold one back so the final cell can carry last
              if (have_prev) cells_due.push_back(prev);
              prev.row = r[0];
              prev.col = k[3:0];
              prev.ch = line_buf[base+r][k];
              prev.last = 1'b0;
              have_prev = 1;
            end
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          cells_due.push_back(prev);
        end
        n_updates++;
      end
    endcase
  endtask

  // driver: bursts of items separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (taken) begin
        void'(cmd_backlog.pop_front());
        taken = 0;
        showing = 0;
      end
      if (!showing) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          func <= cmd_backlog[0].op;
          char_code <= cmd_backlog[0].code;
          scroll_amount <= cmd_backlog[0].amount;
          showing = 1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      start <= showing;
    end
  end

  // monitor: result checking, item capture and watchdog
  always @(posedge clk_i) begin
    panel_cmd_t c;
    cell_t      want;
    if (rst_ni) begin
      quiet_cycles++;
      if (result_valid === 1'b1) begin
        quiet_cycles = 0;
        if (cells_due.size() == 0) begin
          $error("unexpected cell: row %0d, column %0d, char %0d", panel_row,
                 panel_column, out_char);
          errors++;
        end else begin
          want = cells_due.pop_front();
          compare_field("panel_row", 8'(want.row), 8'(panel_row));
          compare_field("panel_column", 8'(want.col), 8'(panel_column));
          compare_field("out_char", want.ch, out_char);
          compare_field("last", 8'(want.last), 8'(last));
          n_cells++;
        end
      end
      if (start && busy === 1'b0) begin
        quiet_cycles = 0;
        c.op = func;
        c.code = char_code;
        c.amount = scroll_amount;
        advance_window(c);
        taken = 1;
        n_items++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d idle cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int         pick;
    int         sel;
    func_e      op;
    logic [7:0] code;
    int         amt;

    for (int l = 0; l < LINES; l++)
      for (int k = 0; k < COLUMNS; k++) line_buf[l][k] = 8'd0;
    for (int r = 0; r < 2; r++)
      for (int k = 0; k < COLUMNS; k++) shadow_buf[r][k] = 8'd0;
    wr_col = 0;
    wr_line = LINES - 2;
    view_back = 0;
    burst_left = $urandom_range(1, 30);
    gap_left = 0;

    // directed: empty update, extreme bytes, scroll saturation both ways,
    // carriage returns forcing a shift, repeated update, clear
    queue_cmd(FUNC_UPDATE, 8'hFF, 8'sd0);
    queue_cmd(FUNC_ADD, 8'hFF, 8'sd0);
    queue_cmd(FUNC_ADD, 8'h00, 8'sd0);
    queue_cmd(FUNC_ADD, 8'h41, -8'sd1);
    queue_cmd(FUNC_UPDATE, 8'h00, 8'sd64);
    queue_cmd(FUNC_SCROLL, 8'hFF, -8'sd64);
    queue_cmd(FUNC_UPDATE, 8'h55, 8'sd0);
    queue_cmd(FUNC_SCROLL, 8'h00, 8'sd64);
    queue_cmd(FUNC_UPDATE, 8'h00, 8'sd0);
    queue_cmd(FUNC_SCROLL, 8'hAA, -8'sd1);
    queue_cmd(FUNC_ADD, CR_CODE, 8'sd0);
    queue_cmd(FUNC_ADD, 8'h7E, 8'sd0);
    queue_cmd(FUNC_ADD, CR_CODE, -8'sd64);
    queue_cmd(FUNC_UPDATE, 8'h00, 8'sd0);
    queue_cmd(FUNC_UPDATE, 8'h00, 8'sd0);
    queue_cmd(FUNC_SCROLL, 8'h00, -8'sd2);
    queue_cmd(FUNC_UPDATE, 8'h00, 8'sd0);
    queue_cmd(FUNC_CLEAR, 8'hFF, -8'sd1);
    queue_cmd(FUNC_UPDATE, 8'h00, 8'sd0);
    queue_cmd(FUNC_ADD, 8'h80, 8'sd0);
    queue_cmd(FUNC_UPDATE, 8'h00, 8'sd0);

    // random: mostly text with carriage returns, interleaved updates
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      code = 8'($urandom_range(0, 255));
      amt = $urandom_range(0, 128);
      amt = amt - 64;
      if (pick < 62) begin
        op = FUNC_ADD;
        sel = $urandom_range(0, 9);
        if (sel == 0) code = CR_CODE;
        else if (sel < 8) code = 8'($urandom_range(32, 126));
      end else if (pick < 82) begin
        op = FUNC_UPDATE;
      end else if (pick < 97) begin
        op = FUNC_SCROLL;
        if ($urandom_range(0, 3) != 0) amt = $urandom_range(0, 6) - 3;
      end else begin
        op = FUNC_CLEAR;
      end
      queue_cmd(op, code, amt[7:0]);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Ran %0d commands: %0d updates, %0d line shifts, %0d clears",
             n_items, n_updates, n_shifts, n_clears);
    $display("Checked %0d changed panel cells", n_cells);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/stw_pkg.sv
src/stw_ctrl.sv
src/stw_datapath.sv
src/scrollback_text_window.sv
src/stw_checker.sv
verif/tb_scrollback_text_window.sv
